// File: sv/priority_task_list_with_class_quotas_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority task list core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_LIST_WITH_CLASS_QUOTAS_CORE_MACROS_SVH
`define PRIORITY_TASK_LIST_WITH_CLASS_QUOTAS_CORE_MACROS_SVH

// Same-cycle implication.
`define PTLCQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTLCQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ptlcq_pkg.sv
// ----------------------------------------------------------------------------
// ptlcq_pkg
// Types and constants shared by the priority task list cells and top level.
// ----------------------------------------------------------------------------
package ptlcq_pkg;

  localparam int POOL_SIZE   = 32;
  localparam int CLASS_COUNT = 7;
  localparam int IDX_W       = $clog2(POOL_SIZE);
  localparam int CNT_W       = $clog2(POOL_SIZE + 1);
  localparam int CLS_W       = 3;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_WALK    = 2'd2;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_REFUSED = 3'd1;
  localparam logic [2:0] STS_EMPTY   = 3'd2;
  localparam logic [2:0] STS_BAD_REL = 3'd3;
  localparam logic [2:0] STS_NONE    = 3'd4;

  localparam logic [15:0] CREDIT_MAX   = 16'hFFFF;
  localparam logic [15:0] QUOTA_RESET  = 16'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] task_type;
    logic [15:0] task_priority;
    logic [31:0] handler_word;
    logic [31:0] aux_word;
    logic [5:0]  release_handle;
    logic [16:0] min_priority;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_handle;
    logic [15:0] out_type;
    logic [15:0] out_priority;
    logic [31:0] out_handler;
    logic [31:0] out_aux;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [5:0]  slot;
    logic [15:0] ttype;
    logic [15:0] prio;
    logic [31:0] handler;
    logic [31:0] aux;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    entry_t     ins;
    logic [5:0] handle;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

endpackage

// File: sv/priority_task_list_with_class_quotas_core.sv
// ----------------------------------------------------------------------------
// priority_task_list_with_class_quotas_core
// Task pool kept as a row of cells sorted by descending priority, with a
// free-slot stack and per-class credit counters.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                          | Transfer when
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_stall, in_data    | in_valid  && !in_stall
//   result  | out_valid, out_stall, out_data | out_valid && !out_stall
//   config  | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// Insert and release complete in the cycle of their input transfer; the
// result sits in the output register from the next cycle on.
// A walk rotates the whole cell row once around, emitting one entry per
// cycle from the head cell while entries qualify; the row is back in order
// when the rotation ends. Output stalls pause the rotation until the walk
// has emitted its final result.
// Reset is synchronous and needs no clearing pass.
module priority_task_list_with_class_quotas_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ptlcq_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ptlcq_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import ptlcq_pkg::*;
  `include "priority_task_list_with_class_quotas_core_macros.svh"

  // Cell row.
  entry_t    cell_q  [POOL_SIZE];
  logic      keep    [POOL_SIZE];
  logic      hit     [POOL_SIZE];
  logic [POOL_SIZE-1:0] cell_valid;
  cell_cmd_t cmd;

  // Bookkeeping state.
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic [16:0]      minp_r, minp_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] free_stk_r [POOL_SIZE];
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [15:0]      credit_r [CLASS_COUNT];
  logic [CLS_W-1:0] slot_cls_r [POOL_SIZE];
  logic [POOL_SIZE-1:0] active_r, active_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r, res_nxt;

  logic             out_free, acc, res_ld;
  logic             push_en, pop_en, cls_wr, cred_dec, cred_inc;
  logic [CLS_W-1:0] cls_sel;
  logic [IDX_W-1:0] pop_slot, rel_idx;
  logic [7:0]       ins_cls;
  logic             head_ok, second_ok;

  genvar g;
  generate
    for (g = 0; g < POOL_SIZE; g++) begin : g_cell
      entry_t prev_e, next_e;
      logic   prev_k, prev_h;
      if (g == 0) begin : g_first
        assign prev_e = '0;
        assign prev_k = 1'b1;
        assign prev_h = 1'b0;
      end else begin : g_mid
        assign prev_e = cell_q[g-1];
        assign prev_k = keep[g-1];
        assign prev_h = hit[g-1];
      end
      if (g == POOL_SIZE - 1) begin : g_last
        // The tail refills with an empty entry on removal, or the head on rotation.
        assign next_e = (cmd.op == CELL_ROTATE) ? cell_q[0] : '0;
      end else begin : g_inner
        assign next_e = cell_q[g+1];
      end
      ptlcq_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_i        (cmd),
        .prev_entry_i (prev_e),
        .next_entry_i (next_e),
        .prev_keep_i  (prev_k),
        .prev_hit_i   (prev_h),
        .entry_o      (cell_q[g]),
        .keep_o       (keep[g]),
        .hit_o        (hit[g])
      );
      assign cell_valid[g] = cell_q[g].valid;
    end
  endgenerate

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign acc      = in_valid && !in_stall;
  assign ins_cls  = in_data.task_type[7:0];
  assign pop_slot = free_stk_r[IDX_W'(free_cnt_r - CNT_W'(1))];
  assign rel_idx  = in_data.release_handle[IDX_W-1:0];
  assign head_ok  = cell_q[0].valid && ({1'b0, cell_q[0].prio} >= minp_r);
  assign second_ok = cell_q[1].valid && ({1'b0, cell_q[1].prio} >= minp_r);

  always_comb begin
    state_nxt    = state_r;
    walk_cnt_nxt = walk_cnt_r;
    minp_nxt     = minp_r;
    done_nxt     = done_r;
    free_cnt_nxt = free_cnt_r;
    active_nxt   = active_r;
    res_ld       = 1'b0;
    res_nxt      = '0;
    push_en      = 1'b0;
    pop_en       = 1'b0;
    cls_wr       = 1'b0;
    cred_dec     = 1'b0;
    cred_inc     = 1'b0;
    cls_sel      = ins_cls[CLS_W-1:0];
    cmd.op       = CELL_HOLD;
    cmd.handle   = in_data.release_handle;
    cmd.ins.valid   = 1'b1;
    cmd.ins.slot    = 6'(pop_slot);
    cmd.ins.ttype   = in_data.task_type;
    cmd.ins.prio    = in_data.task_priority;
    cmd.ins.handler = in_data.handler_word;
    cmd.ins.aux     = in_data.aux_word;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          priority case (in_data.op)
            OP_INSERT: begin
              res_ld       = 1'b1;
              res_nxt.last = 1'b1;
              if ((ins_cls >= 8'(CLASS_COUNT)) || (credit_r[ins_cls[CLS_W-1:0]] == '0)) begin
                res_nxt.status = STS_REFUSED;
              end else if (free_cnt_r == '0) begin
                // The credit stays taken although no slot is given.
                cred_dec       = 1'b1;
                res_nxt.status = STS_EMPTY;
              end else begin
                cred_dec     = 1'b1;
                pop_en       = 1'b1;
                cls_wr       = 1'b1;
                free_cnt_nxt = free_cnt_r - CNT_W'(1);
                active_nxt[pop_slot] = 1'b1;
                cmd.op       = CELL_INSERT;
                res_nxt.status      = STS_OK;
                res_nxt.slot_handle = 6'(pop_slot);
              end
            end
            OP_RELEASE: begin
              res_ld       = 1'b1;
              res_nxt.last = 1'b1;
              cls_sel      = slot_cls_r[rel_idx];
              if ((in_data.release_handle >= 6'(POOL_SIZE)) || !active_r[rel_idx]) begin
                res_nxt.status = STS_BAD_REL;
              end else begin
                active_nxt[rel_idx] = 1'b0;
                cmd.op   = CELL_REMOVE;
                cred_inc = 1'b1;
                if (free_cnt_r < CNT_W'(POOL_SIZE)) begin
                  push_en      = 1'b1;
                  free_cnt_nxt = free_cnt_r + CNT_W'(1);
                end
                res_nxt.status = STS_OK;
              end
            end
            OP_WALK: begin
              state_nxt    = ST_WALK;
              walk_cnt_nxt = '0;
              done_nxt     = 1'b0;
              minp_nxt     = in_data.min_priority;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (done_r || out_free) begin
          cmd.op = CELL_ROTATE;
          if (!done_r) begin
            res_ld   = 1'b1;
            done_nxt = 1'b1;
            if (head_ok) begin
              res_nxt.status       = STS_OK;
              res_nxt.slot_handle  = cell_q[0].slot;
              res_nxt.out_type     = cell_q[0].ttype;
              res_nxt.out_priority = cell_q[0].prio;
              res_nxt.out_handler  = cell_q[0].handler;
              res_nxt.out_aux      = cell_q[0].aux;
              res_nxt.last = (walk_cnt_r == IDX_W'(POOL_SIZE - 1)) || !second_ok;
              done_nxt     = res_nxt.last;
            end else begin
              // Only reachable on the first step: the walk found nothing.
              res_nxt.status = STS_NONE;
              res_nxt.last   = 1'b1;
            end
          end
          walk_cnt_nxt = walk_cnt_r + IDX_W'(1);
          if (walk_cnt_r == IDX_W'(POOL_SIZE - 1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_cnt_r  <= '0;
      done_r      <= 1'b0;
      free_cnt_r  <= CNT_W'(POOL_SIZE);
      active_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) free_stk_r[i] <= IDX_W'(i);
      for (int c = 0; c < CLASS_COUNT; c++) credit_r[c] <= QUOTA_RESET;
    end else begin
      state_r    <= state_nxt;
      walk_cnt_r <= walk_cnt_nxt;
      done_r     <= done_nxt;
      free_cnt_r <= free_cnt_nxt;
      active_r   <= active_nxt;
      if (res_ld) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (push_en) free_stk_r[free_cnt_r[IDX_W-1:0]] <= rel_idx;
      if (cfg_we && (cfg_index < 3'(CLASS_COUNT))) begin
        credit_r[cfg_index] <= cfg_wdata;
      end else if (cred_dec) begin
        credit_r[cls_sel] <= credit_r[cls_sel] - 16'd1;
      end else if (cred_inc && (credit_r[cls_sel] != CREDIT_MAX)) begin
        credit_r[cls_sel] <= credit_r[cls_sel] + 16'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    minp_r <= minp_nxt;
    if (res_ld) out_data_r <= res_nxt;
    if (cls_wr) slot_cls_r[pop_slot] <= cls_sel;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pop_en marks the stack pop; the pointer move is carried in free_cnt_nxt.
  `PTLCQ_ASSERT_IMPL(a_pop_has_slot, pop_en, free_cnt_r != '0, "pop from empty free stack")
  `PTLCQ_ASSERT_IMPL(a_pool_balance, 1'b1,
    ($countones(active_r) + int'(free_cnt_r)) == POOL_SIZE, "active plus free != pool size")
  `PTLCQ_ASSERT_IMPL(a_cells_match_active, state_r == ST_IDLE,
    $countones(cell_valid) == $countones(active_r), "cell row out of step with active set")
  `PTLCQ_ASSERT_NEXT(a_walk_ends,
    (state_r == ST_WALK) && (done_r || out_free) && (walk_cnt_r == IDX_W'(POOL_SIZE - 1)),
    state_r == ST_IDLE, "walk did not end after full rotation")

endmodule

// File: sv/ptlcq_cell.sv
// ----------------------------------------------------------------------------
// ptlcq_cell
// One position of the sorted task row; shifts toward or away from the head.
// ----------------------------------------------------------------------------
module ptlcq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ptlcq_pkg::cell_cmd_t cmd_i,
  input  ptlcq_pkg::entry_t   prev_entry_i,
  input  ptlcq_pkg::entry_t   next_entry_i,
  input  logic                prev_keep_i,
  input  logic                prev_hit_i,
  output ptlcq_pkg::entry_t   entry_o,
  output logic                keep_o,
  output logic                hit_o
);
  import ptlcq_pkg::*;

  entry_t entry_r, entry_nxt;

  // An entry stays put on insert when it ranks equal or above the new task.
  assign keep_o  = entry_r.valid && (entry_r.prio >= cmd_i.ins.prio);
  assign hit_o   = prev_hit_i || (entry_r.valid && (entry_r.slot == cmd_i.handle));
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd_i.op)
      CELL_HOLD: entry_nxt = entry_r;
      CELL_INSERT: begin
        if (keep_o) entry_nxt = entry_r;
        else if (prev_keep_i) entry_nxt = cmd_i.ins;
        else entry_nxt = prev_entry_i;
      end
      CELL_REMOVE: begin
        if (hit_o) entry_nxt = next_entry_i;
      end
      CELL_ROTATE: entry_nxt = next_entry_i;
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule
